// ----- hw/rtl/srrw_pkg.sv -----
// Shared types and codes for the selective-repeat receiver window.
// No dependencies.
package srrw_pkg;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ABORT = 2'd2
    } result_kind_t;

    typedef enum logic {
        OP_DATA    = 1'b0,
        OP_TIMEOUT = 1'b1
    } opcode_t;

    localparam logic [5:0] WINDOW_RESET = 6'd32;

    typedef struct packed {
        result_kind_t kind;
        logic [31:0]  ack_sequence;
        logic [31:0]  sack_bitmap;
        logic         store_chunk;
        logic [31:0]  chunk_index;
        logic [9:0]   payload_bytes;
    } result_t;

endpackage

// ----- hw/rtl/selective_repeat_receiver_window_top.sv -----
// Selective-repeat receiver window: source filter, SACK bitmap and window slide.
// Results are registered; one arriving while another waits goes to the skid register.
// Throughput: one input transfer per cycle; output register plus skid register keep
// input flowing while a result waits, s_ready drops only when both are full.
// Reset (aresetn low, synchronous): window state, source latch and buffer cleared,
// window length returns to 32. Depends on srrw_pkg.
module selective_repeat_receiver_window_top #(
    parameter int unsigned MAX_WINDOW   = 32,
    parameter int unsigned CHUNK_BYTES  = 1000,
    parameter int unsigned HEADER_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_sequence_number,
    input  logic [9:0]  s_packet_length,
    input  logic [31:0] s_source_address,
    input  logic [15:0] s_source_port,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [31:0] m_ack_sequence,
    output logic [31:0] m_sack_bitmap,
    output logic        m_store_chunk,
    output logic [31:0] m_chunk_index,
    output logic [9:0]  m_payload_bytes
);

    localparam logic [5:0]  MAX_WIN  = 6'(MAX_WINDOW);
    localparam logic [16:0] FULL_LEN = 17'(HEADER_BYTES + CHUNK_BYTES);
    localparam logic [9:0]  HDR_LEN  = 10'(HEADER_BYTES);
    localparam logic [15:0] CHUNK_LEN = 16'(CHUNK_BYTES);

    logic [5:0]  win_len_reg;
    logic [31:0] expected_reg,  expected_next;
    logic [31:0] bitmap_reg,    bitmap_next;
    logic        last_seen_reg, last_seen_next;
    logic        latched_reg,   latched_next;
    logic [31:0] lat_addr_reg,  lat_addr_next;
    logic [15:0] lat_port_reg,  lat_port_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    srrw_pkg::result_t    out_reg, out_next;
    srrw_pkg::result_t    skid_reg, skid_next;

    logic                 accept;
    logic                 pop;
    logic                 push;
    srrw_pkg::result_t    res;

    logic [5:0]  win_eff;
    logic [31:0] seq_gap;
    logic [4:0]  bit_idx;
    logic        ahead;
    logic        behind;
    logic        in_win;
    logic        src_ok;
    logic        short_pkt;
    logic [9:0]  bytes_raw;
    logic [9:0]  bytes;
    logic [5:0]  slide;
    logic [5:0]  trail_ones;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    always_comb begin
        if (win_len_reg == 6'd0) begin
            win_eff = 6'd1;
        end else if (win_len_reg > MAX_WIN) begin
            win_eff = MAX_WIN;
        end else begin
            win_eff = win_len_reg;
        end
    end

    assign seq_gap   = s_sequence_number - expected_reg;
    assign bit_idx   = 5'(seq_gap - 32'd1);
    assign ahead     = s_sequence_number > expected_reg;
    assign behind    = s_sequence_number < expected_reg;
    assign in_win    = seq_gap < {26'd0, win_eff};
    assign src_ok    = !latched_reg ||
                       (s_source_address == lat_addr_reg && s_source_port == lat_port_reg);
    assign short_pkt = {7'd0, s_packet_length} < FULL_LEN;
    assign bytes_raw = (s_packet_length > HDR_LEN) ? (s_packet_length - HDR_LEN) : 10'd0;
    assign bytes     = ({6'd0, bytes_raw} > CHUNK_LEN) ? CHUNK_LEN[9:0] : bytes_raw;

    // trailing run of set bits; slide is that run plus one, capped at the window
    always_comb begin
        trail_ones = 6'd32;
        for (int i = 31; i >= 0; i--) begin
            if (!bitmap_reg[i]) begin
                trail_ones = 6'(i);
            end
        end
        slide = (trail_ones < win_eff) ? (trail_ones + 6'd1) : win_eff;
    end

    always_comb begin
        expected_next  = expected_reg;
        bitmap_next    = bitmap_reg;
        last_seen_next = last_seen_reg;
        latched_next   = latched_reg;
        lat_addr_next  = lat_addr_reg;
        lat_port_next  = lat_port_reg;
        push           = 1'b0;
        res.kind          = srrw_pkg::KIND_ACK;
        res.ack_sequence  = expected_reg;
        res.sack_bitmap   = bitmap_reg;
        res.store_chunk   = 1'b0;
        res.chunk_index   = 32'd0;
        res.payload_bytes = 10'd0;
        if (accept) begin
            if (s_opcode == srrw_pkg::OP_TIMEOUT) begin
                push     = 1'b1;
                res.kind = last_seen_reg ? srrw_pkg::KIND_DONE : srrw_pkg::KIND_ABORT;
            end else begin
                if (!latched_reg) begin
                    latched_next  = 1'b1;
                    lat_addr_next = s_source_address;
                    lat_port_next = s_source_port;
                end
                if (src_ok) begin
                    push = 1'b1;
                    if (short_pkt) begin
                        last_seen_next = 1'b1;
                    end
                    if (ahead) begin
                        if (in_win) begin
                            bitmap_next       = bitmap_reg | (32'd1 << bit_idx);
                            res.store_chunk   = 1'b1;
                            res.chunk_index   = s_sequence_number;
                            res.payload_bytes = bytes;
                        end
                    end else if (!behind) begin
                        expected_next     = expected_reg + {26'd0, slide};
                        bitmap_next       = bitmap_reg >> slide;
                        res.store_chunk   = 1'b1;
                        res.chunk_index   = s_sequence_number;
                        res.payload_bytes = bytes;
                    end
                    res.ack_sequence = expected_next;
                    res.sack_bitmap  = bitmap_next;
                end
            end
        end
    end

    // two-entry in-order output buffer
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_next       = res;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg     <= srrw_pkg::WINDOW_RESET;
            expected_reg    <= 32'd0;
            bitmap_reg      <= 32'd0;
            last_seen_reg   <= 1'b0;
            latched_reg     <= 1'b0;
            lat_addr_reg    <= 32'd0;
            lat_port_reg    <= 16'd0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                win_len_reg <= cfg_wr_data;
            end
            expected_reg    <= expected_next;
            bitmap_reg      <= bitmap_next;
            last_seen_reg   <= last_seen_next;
            latched_reg     <= latched_next;
            lat_addr_reg    <= lat_addr_next;
            lat_port_reg    <= lat_port_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_reg.kind;
    assign m_ack_sequence  = out_reg.ack_sequence;
    assign m_sack_bitmap   = out_reg.sack_bitmap;
    assign m_store_chunk   = out_reg.store_chunk;
    assign m_chunk_index   = out_reg.chunk_index;
    assign m_payload_bytes = out_reg.payload_bytes;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_bitmap_top_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !bitmap_reg[31])
        else $error("bitmap bit beyond window set");

    a_nostore_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_store_chunk) |-> (m_chunk_index == 32'd0 && m_payload_bytes == 10'd0))
        else $error("non-store result carries chunk fields");

    a_store_is_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_store_chunk) |-> (m_result_kind == srrw_pkg::KIND_ACK))
        else $error("store flagged on timeout result");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("pending result changed");

endmodule
